// File: rtl/rafp_pkg.sv
// ----------------------------------------------------------------------------
// rafp_pkg
// Types, codes and helpers shared by the array frame parser.
// ----------------------------------------------------------------------------
package rafp_pkg;

   localparam int MESSAGE_BYTES_DEF = 65536;
   localparam int ACC_W             = 21;
   localparam int CNT_W             = 12;
   localparam int IDX_W             = 11;
   localparam int START_W           = 16;
   localparam int CSR_IDX_W         = 2;

   localparam logic [ACC_W-1:0] ACC_SAT          = 21'h1FFFFF;
   localparam logic [CNT_W-1:0] MAX_ARGS_RST     = 12'd2048;
   localparam logic [ACC_W-1:0] MAX_BULK_LEN_RST = 21'd1048576;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_ARGS     = 2'd0,
      CSR_MAX_BULK_LEN = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_ARG    = 2'd0,
      EV_ACCEPT = 2'd1,
      EV_REJECT = 2'd2
   } event_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_ARRAY_HDR = 3'd1,
      ERR_BULK_HDR  = 3'd2,
      ERR_CRLF      = 3'd3,
      ERR_TRUNCATED = 3'd4
   } error_code_type;

   typedef enum logic [2:0] {
      PH_STAR      = 3'd0,
      PH_DIGITS    = 3'd1,
      PH_HDR_SKIP  = 3'd2,
      PH_MARK      = 3'd3,
      PH_BULK_SKIP = 3'd4,
      PH_PAYLOAD   = 3'd5,
      PH_TRAILER   = 3'd6,
      PH_IGNORE    = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [IDX_W-1:0]   arg_index;
      logic [START_W-1:0] arg_start;
      logic [ACC_W-1:0]   arg_length;
      logic [CNT_W-1:0]   arg_count;
      logic [2:0]         error_code;
      logic               last_of_run;
   } rsp_type;

   function automatic logic number_ok(
      input logic [ACC_W-1:0] accum,
      input logic             seen,
      input logic [CNT_W-1:0] expected,
      input logic [CNT_W-1:0] arg_limit,
      input logic [ACC_W-1:0] max_bulk_len
   );
      logic ok;
      if (!seen || accum == ACC_SAT) begin
         ok = 1'b0;
      end else if (expected == '0) begin
         ok = (accum != '0) && (accum <= ACC_W'(arg_limit));
      end else begin
         ok = (accum <= max_bulk_len);
      end
      return ok;
   endfunction

endpackage

// File: rtl/resp_array_frame_parser.sv
// ----------------------------------------------------------------------------
// resp_array_frame_parser
// Byte-stream parser for an array of bulk strings with argument reports.
// ----------------------------------------------------------------------------
// Feed the request one byte per req beat; mark the final byte with
// end_of_message. Each byte is parsed in the cycle it is accepted, and the
// results it causes (an argument report, a verdict, or both) land in a
// three-entry result queue whose registered head is shown on rsp.
// Throughput is one byte per cycle while req_ready is high, set by the
// combinational state update (multiply by ten and range compare) and the
// one-result-per-cycle drain of the queue; a byte with two results
// enqueues both. req_ready is low while two or more results wait, so a
// stalled receiver backs up into the sender with no result lost. Reset
// empties the queue, returns the parser to waiting for '*' and loads an
// argument limit of 2048 and max_bulk_len = 1048576. The byte at offset
// MESSAGE_BYTES - 2 ends the message even without end_of_message. csr
// writes take effect at the next edge; write only while idle.
// ----------------------------------------------------------------------------
module resp_array_frame_parser #(
   parameter int MESSAGE_BYTES = rafp_pkg::MESSAGE_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rafp_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rafp_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [rafp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rafp_pkg::ACC_W-1:0]         csr_wdata
);

   localparam int OFS_W = $clog2(MESSAGE_BYTES);
   localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(MESSAGE_BYTES - 2);
   localparam int QD = 3;

   logic [rafp_pkg::CNT_W-1:0] arg_limit_ff;
   logic [rafp_pkg::ACC_W-1:0] max_bulk_len_ff;

   rafp_pkg::phase_type        phase_ff, phase_in;
   logic [rafp_pkg::ACC_W-1:0] accum_ff, accum_in;
   logic                       seen_ff, seen_in;
   logic                       cr_ff, cr_in;
   logic [rafp_pkg::CNT_W-1:0] expected_ff, expected_in;
   logic [rafp_pkg::CNT_W-1:0] done_ff, done_in;
   logic [OFS_W-1:0]           offset_ff, offset_in;
   logic [rafp_pkg::ACC_W-1:0] left_ff, left_in;
   logic [rafp_pkg::START_W-1:0] begin_ff, begin_in;

   rafp_pkg::rsp_type q_ff [QD];
   rafp_pkg::rsp_type q_in [QD];
   logic [1:0]        cnt_ff, cnt_in;

   logic              req_accept;
   logic              pop;
   rafp_pkg::rsp_type res0, res1;
   logic [1:0]        nres;

   assign req_ready  = (cnt_ff <= 2'd1);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_data   = q_ff[0];
   assign pop        = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_limit_ff    <= rafp_pkg::MAX_ARGS_RST;
         max_bulk_len_ff <= rafp_pkg::MAX_BULK_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            rafp_pkg::CSR_MAX_ARGS:
               arg_limit_ff <= csr_wdata[rafp_pkg::CNT_W-1:0];
            rafp_pkg::CSR_MAX_BULK_LEN:
               max_bulk_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic                       eom;
      logic [rafp_pkg::ACC_W+3:0] prod;
      logic [31:0]                begin_wide;
      rafp_pkg::error_code_type   err;

      phase_in    = phase_ff;
      accum_in    = accum_ff;
      seen_in     = seen_ff;
      cr_in       = cr_ff;
      expected_in = expected_ff;
      done_in     = done_ff;
      offset_in   = offset_ff;
      left_in     = left_ff;
      begin_in    = begin_ff;
      res0        = '0;
      res1        = '0;
      nres        = 2'd0;
      err         = rafp_pkg::ERR_NONE;
      eom         = req_data.end_of_message || (offset_ff >= OFS_LAST);
      prod        = ((rafp_pkg::ACC_W+4)'(accum_ff) << 3) + ((rafp_pkg::ACC_W+4)'(accum_ff) << 1)
                  + (rafp_pkg::ACC_W+4)'(req_data.data_byte - rafp_pkg::CH_ZERO);
      begin_wide  = 32'(offset_ff) + 32'd1;

      if (req_accept) begin
         unique case (phase_ff)
            rafp_pkg::PH_STAR: begin
               if (req_data.data_byte == rafp_pkg::CH_STAR) begin
                  phase_in = rafp_pkg::PH_DIGITS;
                  accum_in = '0;
                  seen_in  = 1'b0;
               end else begin
                  err = rafp_pkg::ERR_ARRAY_HDR;
               end
            end
            rafp_pkg::PH_DIGITS: begin
               if (req_data.data_byte >= rafp_pkg::CH_ZERO &&
                   req_data.data_byte <= rafp_pkg::CH_NINE) begin
                  accum_in = (prod > (rafp_pkg::ACC_W+4)'(rafp_pkg::ACC_SAT)) ?
                             rafp_pkg::ACC_SAT : prod[rafp_pkg::ACC_W-1:0];
                  seen_in  = 1'b1;
               end else if (!rafp_pkg::number_ok(accum_ff, seen_ff, expected_ff,
                                                 arg_limit_ff, max_bulk_len_ff)) begin
                  err = (expected_ff == '0) ? rafp_pkg::ERR_ARRAY_HDR :
                                              rafp_pkg::ERR_BULK_HDR;
               end else begin
                  if (expected_ff == '0) begin
                     expected_in = accum_ff[rafp_pkg::CNT_W-1:0];
                     phase_in    = rafp_pkg::PH_HDR_SKIP;
                  end else begin
                     left_in  = accum_ff;
                     phase_in = rafp_pkg::PH_BULK_SKIP;
                  end
                  cr_in = (req_data.data_byte == rafp_pkg::CH_CR);
               end
            end
            rafp_pkg::PH_HDR_SKIP, rafp_pkg::PH_BULK_SKIP: begin
               if (cr_ff && req_data.data_byte == rafp_pkg::CH_LF) begin
                  cr_in = 1'b0;
                  if (phase_ff == rafp_pkg::PH_HDR_SKIP) begin
                     phase_in = rafp_pkg::PH_MARK;
                  end else begin
                     begin_in        = begin_wide[rafp_pkg::START_W-1:0];
                     res0.event_kind = rafp_pkg::EV_ARG;
                     res0.arg_index  = done_ff[rafp_pkg::IDX_W-1:0];
                     res0.arg_start  = begin_wide[rafp_pkg::START_W-1:0];
                     res0.arg_length = left_ff;
                     nres            = 2'd1;
                     phase_in = (left_ff == '0) ? rafp_pkg::PH_TRAILER :
                                                  rafp_pkg::PH_PAYLOAD;
                  end
               end else begin
                  cr_in = (req_data.data_byte == rafp_pkg::CH_CR);
               end
            end
            rafp_pkg::PH_MARK: begin
               if (req_data.data_byte == rafp_pkg::CH_DOLLAR) begin
                  phase_in = rafp_pkg::PH_DIGITS;
                  accum_in = '0;
                  seen_in  = 1'b0;
               end else begin
                  err = rafp_pkg::ERR_BULK_HDR;
               end
            end
            rafp_pkg::PH_PAYLOAD: begin
               if (left_ff != '0) begin
                  left_in = left_ff - 1'b1;
               end
               if (left_in == '0) begin
                  phase_in = rafp_pkg::PH_TRAILER;
               end
            end
            rafp_pkg::PH_TRAILER: begin
               if (!cr_ff) begin
                  if (req_data.data_byte == rafp_pkg::CH_CR) begin
                     cr_in = 1'b1;
                  end else begin
                     err = rafp_pkg::ERR_CRLF;
                  end
               end else if (req_data.data_byte == rafp_pkg::CH_LF) begin
                  cr_in   = 1'b0;
                  done_in = done_ff + 1'b1;
                  if (done_in == expected_ff) begin
                     res0.event_kind = rafp_pkg::EV_ACCEPT;
                     res0.arg_count  = expected_ff;
                     nres            = 2'd1;
                     phase_in        = rafp_pkg::PH_IGNORE;
                  end else begin
                     phase_in = rafp_pkg::PH_MARK;
                  end
               end else begin
                  err = rafp_pkg::ERR_CRLF;
               end
            end
            default: ;
         endcase

         if (err == rafp_pkg::ERR_NONE && eom && phase_in != rafp_pkg::PH_IGNORE) begin
            unique case (phase_in)
               rafp_pkg::PH_STAR:
                  err = rafp_pkg::ERR_ARRAY_HDR;
               rafp_pkg::PH_DIGITS:
                  if (rafp_pkg::number_ok(accum_in, seen_in, expected_in,
                                          arg_limit_ff, max_bulk_len_ff)) begin
                     err = rafp_pkg::ERR_CRLF;
                  end else begin
                     err = (expected_in == '0) ? rafp_pkg::ERR_ARRAY_HDR :
                                                 rafp_pkg::ERR_BULK_HDR;
                  end
               rafp_pkg::PH_HDR_SKIP, rafp_pkg::PH_BULK_SKIP:
                  err = rafp_pkg::ERR_CRLF;
               default:
                  err = rafp_pkg::ERR_TRUNCATED;
            endcase
         end

         if (err != rafp_pkg::ERR_NONE) begin
            if (nres == 2'd0) begin
               res0.event_kind = rafp_pkg::EV_REJECT;
               res0.error_code = err;
            end else begin
               res1.event_kind = rafp_pkg::EV_REJECT;
               res1.error_code = err;
            end
            nres     = nres + 2'd1;
            phase_in = rafp_pkg::PH_IGNORE;
         end

         if (nres == 2'd1) begin
            res0.last_of_run = 1'b1;
         end else if (nres == 2'd2) begin
            res1.last_of_run = 1'b1;
         end

         if (eom) begin
            phase_in    = rafp_pkg::PH_STAR;
            accum_in    = '0;
            seen_in     = 1'b0;
            cr_in       = 1'b0;
            expected_in = '0;
            done_in     = '0;
            offset_in   = '0;
            left_in     = '0;
            begin_in    = '0;
         end else begin
            offset_in = offset_ff + 1'b1;
         end
      end
   end

   always_comb begin
      logic [1:0] base;
      base = cnt_ff - {1'b0, pop};
      for (int i = 0; i < QD; i++) begin
         if (pop && i < QD - 1) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (nres != 2'd0 && 2'(i) == base) begin
            q_in[i] = res0;
         end
         if (nres == 2'd2 && 2'(i) == base + 2'd1) begin
            q_in[i] = res1;
         end
      end
      cnt_in = base + nres;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rafp_pkg::PH_STAR;
         accum_ff    <= '0;
         seen_ff     <= 1'b0;
         cr_ff       <= 1'b0;
         expected_ff <= '0;
         done_ff     <= '0;
         offset_ff   <= '0;
         left_ff     <= '0;
         begin_ff    <= '0;
         cnt_ff      <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         accum_ff    <= accum_in;
         seen_ff     <= seen_in;
         cr_ff       <= cr_in;
         expected_ff <= expected_in;
         done_ff     <= done_in;
         offset_ff   <= offset_in;
         left_ff     <= left_in;
         begin_ff    <= begin_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QD; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   a_eom_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.end_of_message
      |=> phase_ff == rafp_pkg::PH_STAR && offset_ff == '0 && done_ff == '0)
      else $error("parser not cleared after final byte");

   a_run_pairs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> cnt_ff >= 2'd2)
      else $error("result run split across queue");

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rafp_pkg::PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with nothing left");

endmodule

// File: tb/sv/tb_resp_array_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_resp_array_frame_parser
// Self-checking bench for the array-of-bulk-strings frame parser. Messages
// are built with random content and at times bad counts or lengths, a share
// of them damaged (cut short, a byte replaced, a byte inserted), and fed one
// byte per beat. A scoreboard tracks the parser state on every accepted byte
// and checks each argument report and verdict in order. The run moves
// through several register settings and sender/receiver pacing modes.
// ----------------------------------------------------------------------------
module tb_resp_array_frame_parser;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MSG_BYTES    = rafp_pkg::MESSAGE_BYTES_DEF;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned PHASE_BYTES  = 200;
   localparam int          NUM_PHASES   = 8;
   localparam int unsigned ARGS_SET [NUM_PHASES] =
      '{2048, 1, 1, 2048, 3, 4, 2, 2048};
   localparam int unsigned BULK_SET [NUM_PHASES] =
      '{1048576, 0, 1048576, 0, 7, 3, 12, 1048576};

   localparam logic [rafp_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [rafp_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [7:0]                     CH_SPACE    = 8'h20;
   localparam logic [7:0]                     CH_LOWER_A  = 8'h61;

   class frame_scoreboard;
      logic [rafp_pkg::CNT_W-1:0]   arg_limit;
      logic [rafp_pkg::ACC_W-1:0]   max_bulk_len;
      rafp_pkg::phase_type          phase;
      logic [rafp_pkg::ACC_W-1:0]   accum;
      bit                           seen;
      bit                           cr_pend;
      logic [rafp_pkg::CNT_W-1:0]   want_args;
      logic [rafp_pkg::CNT_W-1:0]   done_args;
      logic [rafp_pkg::START_W-1:0] offset;
      logic [rafp_pkg::ACC_W-1:0]   left;
      logic [rafp_pkg::START_W-1:0] first;
      rafp_pkg::rsp_type            events_due [$];
      int unsigned                  mismatches;
      int unsigned                  byte_count;
      int unsigned                  live_bytes;
      int unsigned                  arg_reports;
      int unsigned                  accepts;
      int unsigned                  rejects;

      function new();
         arg_limit    = rafp_pkg::MAX_ARGS_RST;
         max_bulk_len = rafp_pkg::MAX_BULK_LEN_RST;
         clear();
      endfunction

      function void clear();
         phase     = rafp_pkg::PH_STAR;
         accum     = '0;
         seen      = 1'b0;
         cr_pend   = 1'b0;
         want_args = '0;
         done_args = '0;
         offset    = '0;
         left      = '0;
         first     = '0;
      endfunction

      function int pending();
         return events_due.size();
      endfunction

      function void write_reg(logic [rafp_pkg::CSR_IDX_W-1:0] idx,
                              logic [rafp_pkg::ACC_W-1:0] value);
         case (idx)
            rafp_pkg::CSR_MAX_ARGS:     arg_limit = value[rafp_pkg::CNT_W-1:0];
            rafp_pkg::CSR_MAX_BULK_LEN: max_bulk_len = value;
            default: ;
         endcase
      endfunction

      function bit value_fits();
         if (!seen || accum == rafp_pkg::ACC_SAT) return 1'b0;
         if (want_args == '0) return (accum >= 1) && (accum <= arg_limit);
         return accum <= max_bulk_len;
      endfunction

      function rafp_pkg::rsp_type event_of(logic [1:0] kind,
                                           logic [rafp_pkg::IDX_W-1:0] idx,
                                           logic [rafp_pkg::START_W-1:0] pos,
                                           logic [rafp_pkg::ACC_W-1:0] len,
                                           logic [rafp_pkg::CNT_W-1:0] cnt,
                                           logic [2:0] err);
         rafp_pkg::rsp_type e;
         e.event_kind  = kind;
         e.arg_index   = idx;
         e.arg_start   = pos;
         e.arg_length  = len;
         e.arg_count   = cnt;
         e.error_code  = err;
         e.last_of_run = 1'b0;
         return e;
      endfunction

      function void note_byte(rafp_pkg::req_type r);
         logic [7:0]        b;
         bit                eom;
         logic [2:0]        err;
         int unsigned       prod;
         rafp_pkg::rsp_type ev [$];
         b   = r.data_byte;
         eom = r.end_of_message || (int'(offset) >= MSG_BYTES - 2);
         err = rafp_pkg::ERR_NONE;
         byte_count++;
         if (phase != rafp_pkg::PH_IGNORE) live_bytes++;
         case (phase)
            rafp_pkg::PH_STAR: begin
               if (b == rafp_pkg::CH_STAR) begin
                  phase = rafp_pkg::PH_DIGITS;
                  accum = '0;
                  seen  = 1'b0;
               end else begin
                  err = rafp_pkg::ERR_ARRAY_HDR;
               end
            end
            rafp_pkg::PH_DIGITS: begin
               if (b >= rafp_pkg::CH_ZERO && b <= rafp_pkg::CH_NINE) begin
                  prod  = 32'(accum) * 10 + 32'(b - rafp_pkg::CH_ZERO);
                  accum = (prod > rafp_pkg::ACC_SAT) ? rafp_pkg::ACC_SAT :
                                                       prod[rafp_pkg::ACC_W-1:0];
                  seen  = 1'b1;
               end else if (!value_fits()) begin
                  err = (want_args == '0) ? rafp_pkg::ERR_ARRAY_HDR :
                                            rafp_pkg::ERR_BULK_HDR;
               end else begin
                  if (want_args == '0) begin
                     want_args = accum[rafp_pkg::CNT_W-1:0];
                     phase     = rafp_pkg::PH_HDR_SKIP;
                  end else begin
                     left  = accum;
                     phase = rafp_pkg::PH_BULK_SKIP;
                  end
                  cr_pend = (b == rafp_pkg::CH_CR);
               end
            end
            rafp_pkg::PH_HDR_SKIP, rafp_pkg::PH_BULK_SKIP: begin
               if (cr_pend && b == rafp_pkg::CH_LF) begin
                  cr_pend = 1'b0;
                  if (phase == rafp_pkg::PH_HDR_SKIP) begin
                     phase = rafp_pkg::PH_MARK;
                  end else begin
                     first = offset + 1'b1;
                     ev.push_back(event_of(rafp_pkg::EV_ARG,
                                           done_args[rafp_pkg::IDX_W-1:0], first, left,
                                           '0, rafp_pkg::ERR_NONE));
                     arg_reports++;
                     if (left == '0) begin
                        phase = rafp_pkg::PH_TRAILER;
                     end else begin
                        phase = rafp_pkg::PH_PAYLOAD;
                     end
                  end
               end else begin
                  cr_pend = (b == rafp_pkg::CH_CR);
               end
            end
            rafp_pkg::PH_MARK: begin
               if (b == rafp_pkg::CH_DOLLAR) begin
                  phase = rafp_pkg::PH_DIGITS;
                  accum = '0;
                  seen  = 1'b0;
               end else begin
                  err = rafp_pkg::ERR_BULK_HDR;
               end
            end
            rafp_pkg::PH_PAYLOAD: begin
               if (left != '0) left = left - 1'b1;
               if (left == '0) phase = rafp_pkg::PH_TRAILER;
            end
            rafp_pkg::PH_TRAILER: begin
               if (!cr_pend) begin
                  if (b == rafp_pkg::CH_CR) begin
                     cr_pend = 1'b1;
                  end else begin
                     err = rafp_pkg::ERR_CRLF;
                  end
               end else if (b == rafp_pkg::CH_LF) begin
                  cr_pend   = 1'b0;
                  done_args = done_args + 1'b1;
                  if (done_args == want_args) begin
                     ev.push_back(event_of(rafp_pkg::EV_ACCEPT, '0, '0, '0, want_args,
                                           rafp_pkg::ERR_NONE));
                     accepts++;
                     phase = rafp_pkg::PH_IGNORE;
                  end else begin
                     phase = rafp_pkg::PH_MARK;
                  end
               end else begin
                  err = rafp_pkg::ERR_CRLF;
               end
            end
            default: ;
         endcase

         if (err == rafp_pkg::ERR_NONE && eom && phase != rafp_pkg::PH_IGNORE) begin
            case (phase)
               rafp_pkg::PH_STAR: err = rafp_pkg::ERR_ARRAY_HDR;
               rafp_pkg::PH_DIGITS: begin
                  if (value_fits()) begin
                     err = rafp_pkg::ERR_CRLF;
                  end else begin
                     err = (want_args == '0) ? rafp_pkg::ERR_ARRAY_HDR :
                                               rafp_pkg::ERR_BULK_HDR;
                  end
               end
               rafp_pkg::PH_HDR_SKIP, rafp_pkg::PH_BULK_SKIP: err = rafp_pkg::ERR_CRLF;
               default: err = rafp_pkg::ERR_TRUNCATED;
            endcase
         end

         if (err != rafp_pkg::ERR_NONE) begin
            ev.push_back(event_of(rafp_pkg::EV_REJECT, '0, '0, '0, '0, err));
            rejects++;
            phase = rafp_pkg::PH_IGNORE;
         end

         if (eom) begin
            clear();
         end else begin
            offset = offset + 1'b1;
         end

         if (ev.size() > 0) ev[ev.size()-1].last_of_run = 1'b1;
         foreach (ev[i]) events_due.push_back(ev[i]);
      endfunction

      function string show(rafp_pkg::rsp_type e);
         return $sformatf("kind=%0d idx=%0d start=%0d len=%0d count=%0d err=%0d last=%0d",
                          e.event_kind, e.arg_index, e.arg_start, e.arg_length,
                          e.arg_count, e.error_code, e.last_of_run);
      endfunction

      function void check_event(rafp_pkg::rsp_type got);
         rafp_pkg::rsp_type want;
         if (events_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result with nothing due: %s", $time, show(got));
         end else begin
            want = events_due.pop_front();
            if (got.event_kind !== want.event_kind || got.arg_index !== want.arg_index ||
                got.arg_start !== want.arg_start || got.arg_length !== want.arg_length ||
                got.arg_count !== want.arg_count || got.error_code !== want.error_code ||
                got.last_of_run !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("[%0t] mismatch, expected %s", $time, show(want));
                  $display("[%0t]           actual   %s", $time, show(got));
               end
            end
         end
      endfunction
   endclass

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   rafp_pkg::req_type              req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   rafp_pkg::rsp_type              rsp_data;
   logic                           csr_we    = 1'b0;
   logic [rafp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rafp_pkg::ACC_W-1:0]     csr_wdata = '0;

   frame_scoreboard sb = new();
   logic [7:0]      frame_q [$];
   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     cycle_count    = 0;
   int unsigned     messages       = 0;
   int unsigned     settings       = 0;

   resp_array_frame_parser #(.MESSAGE_BYTES(MSG_BYTES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_event(rsp_data);
         if (req_valid && req_ready) sb.note_byte(req_data);
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d results due", cycle_count, sb.pending());
      $display("FAIL resp_array_frame_parser");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic eom);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, end_of_message: eom};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_frame(input bit with_eom);
      for (int i = 0; i < frame_q.size(); i++) begin
         send_byte(frame_q[i], with_eom && (i == frame_q.size() - 1));
      end
      frame_q.delete();
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rafp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rafp_pkg::ACC_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
   endfunction

   function automatic void push_crlf();
      frame_q.push_back(rafp_pkg::CH_CR);
      frame_q.push_back(rafp_pkg::CH_LF);
   endfunction

   function automatic void push_number(int unsigned v);
      if ($urandom_range(19) == 0) return;
      repeat (($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0)
         frame_q.push_back(rafp_pkg::CH_ZERO);
      push_text($sformatf("%0d", v));
   endfunction

   // filler between a number and its CR LF, sometimes with a lone CR
   function automatic void push_skip();
      int n;
      n = ($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) begin
         case ($urandom_range(3))
            0: frame_q.push_back(rafp_pkg::CH_CR);
            1: frame_q.push_back(CH_SPACE);
            default: frame_q.push_back(CH_LOWER_A + 8'($urandom_range(25)));
         endcase
      end
      push_crlf();
   endfunction

   function automatic int unsigned pick_count();
      int unsigned top;
      top = (sb.arg_limit < 4) ? sb.arg_limit : 4;
      case ($urandom_range(19))
         0: return sb.arg_limit;
         1: return sb.arg_limit + 1;
         2: return 0;
         3: return $urandom_range(1) ? 32'(rafp_pkg::ACC_SAT) : 32'd98765432;
         default: return $urandom_range(1, top);
      endcase
   endfunction

   function automatic int unsigned pick_length();
      int unsigned top;
      top = (sb.max_bulk_len < 12) ? sb.max_bulk_len : 12;
      case ($urandom_range(19))
         0: return sb.max_bulk_len;
         1: return sb.max_bulk_len + 1;
         2: return 32'(rafp_pkg::ACC_SAT) - 1;
         3: return $urandom_range(1) ? 32'(rafp_pkg::ACC_SAT) : 32'd123456789;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   task automatic send_message();
      int unsigned argc;
      int unsigned len;
      int unsigned n;
      int unsigned k;
      argc = pick_count();
      frame_q.push_back(rafp_pkg::CH_STAR);
      push_number(argc);
      push_skip();
      for (int i = 0; i < argc && i < 6; i++) begin
         len = pick_length();
         frame_q.push_back(rafp_pkg::CH_DOLLAR);
         push_number(len);
         push_skip();
         n = (len > 24) ? $urandom_range(0, 20) : len;
         repeat (n) frame_q.push_back(8'($urandom));
         if (n < len) break;
         push_crlf();
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      case ($urandom_range(7))
         0: begin
            k = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > k) void'(frame_q.pop_back());
         end
         1: frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom);
         2: frame_q.insert($urandom_range(0, frame_q.size() - 1), 8'($urandom));
         default: ;
      endcase
      messages++;
      send_frame(1'b1);
   endtask

   initial begin
      int unsigned phase_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push_text("*1"); push_crlf(); push_text("$0"); push_crlf(); push_crlf();
      send_frame(1'b1);
      frame_q.push_back(8'hFF);
      send_frame(1'b1);
      frame_q.push_back(8'h00);
      send_frame(1'b1);
      push_text("*2"); push_crlf(); push_text("$3"); push_crlf();
      push_text("abc"); push_crlf(); push_text("$");
      send_frame(1'b1);
      messages += 4;

      for (int p = 0; p < NUM_PHASES; p++) begin
         hold_until_drained();
         repeat (4) @(posedge clock);
         if (p == 0) begin
            write_reg(CSR_SPARE_A, 21'($urandom));
            write_reg(CSR_SPARE_B, 21'($urandom));
         end
         write_reg(rafp_pkg::CSR_MAX_ARGS, {9'($urandom), 12'(ARGS_SET[p])});
         write_reg(rafp_pkg::CSR_MAX_BULK_LEN, 21'(BULK_SET[p]));
         settings++;
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         phase_start = sb.byte_count;
         while (sb.byte_count - phase_start < PHASE_BYTES) begin
            send_message();
            if ($urandom_range(7) == 0) hold_until_drained();
         end
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      $display("Covered %0d bytes (%0d parsed) in %0d messages under %0d register settings:",
               sb.byte_count, sb.live_bytes, messages, settings);
      $display("  %0d argument reports, %0d accepted, %0d rejected, %0d mismatches",
               sb.arg_reports, sb.accepts, sb.rejects, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS resp_array_frame_parser");
      end else begin
         $display("FAIL resp_array_frame_parser");
      end
      $finish;
   end

endmodule
